// ===== hw/rtl/lla_pkg.sv =====
// Package for the LED light animator.
// Holds the sequencer state type, register indexes, mode and level codes and constants.
// No dependencies.
package lla_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_FREQ,
        ST_COUNT,
        ST_MOVE,
        ST_BODY,
        ST_SCALE,
        ST_OUT
    } lla_state_t;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_LEVEL    = 2'd1;
    localparam logic [1:0] CFG_BRIGHT   = 2'd2;
    localparam logic [1:0] CFG_THROTTLE = 2'd3;

    localparam logic [1:0] MODE_SOLID  = 2'd0;
    localparam logic [1:0] MODE_ROTATE = 2'd1;
    localparam logic [1:0] MODE_GLOW   = 2'd2;

    localparam logic [1:0] LEVEL_OFF  = 2'd0;
    localparam logic [1:0] LEVEL_LOW  = 2'd1;
    localparam logic [1:0] LEVEL_HIGH = 2'd2;

    localparam logic [9:0]  MOVE_NUM   = 10'(31 << 5);
    localparam logic [7:0]  SPON_LOW   = 8'h40;
    localparam logic [7:0]  SPON_HIGH  = 8'hFF;
    localparam logic [15:0] ROUND_HALF = 16'(1 << 4);
    localparam logic [8:0]  FRAC_ONE   = 9'(1 << 6);
    localparam logic [11:0] THR_ROUND  = 12'(1 << 3);
    localparam logic [10:0] BRT_FLOOR  = 11'd32;
    localparam logic [7:0]  FREQ_MAX   = 8'd255;
    localparam logic [7:0]  SPD_MIN    = 8'd4;
    localparam logic [5:0]  SHIFT_MAX  = 6'd36;

endpackage

// ===== hw/rtl/led_light_animator.sv =====
// Top level of the LED light animator: config registers, sequencer and shared datapath.
// Depends on lla_pkg.
//
// Each tick transfer yields one result transfer. In solid mode the result is ready in the
// cycle after the tick is taken. In rotate and glow mode the steps are: one multiply for
// the phase, eight divider steps for the move interval, eight divider steps for the shift
// count, one multiply for the move time, four multiplies (a single step with no multiply
// in glow) for the body values and four multiplies for brightness scaling. The steps are
// set by the single shared 16x9 multiplier and the one-bit-per-cycle divider. The input is
// not ready from the tick transfer until the result has been transferred.
module led_light_animator
    import lla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  duty_0,
    output logic [7:0]  duty_1,
    output logic [7:0]  duty_2,
    output logic [7:0]  duty_3,
    output logic [7:0]  sponson_level,
    output logic [5:0]  shift_count,
    output logic [7:0]  inserted_level
);

    lla_state_t state_reg, state_next;

    logic [1:0]  mode_reg;
    logic [1:0]  level_reg;
    logic [10:0] bright_reg;
    logic [10:0] throttle_reg;
    logic [7:0]  lmt_reg, lmt_next;

    logic [15:0] now_reg, now_next;
    logic [7:0]  brt_reg, brt_next;
    logic [7:0]  spon_reg, spon_next;
    logic [7:0]  spd_reg, spd_next;
    logic [7:0]  cp_reg, cp_next;
    logic [7:0]  freq_reg, freq_next;
    logic [5:0]  count_reg, count_next;
    logic [7:0]  ins_reg, ins_next;
    logic [7:0]  v_reg [4];
    logic [7:0]  v_next [4];
    logic [7:0]  duty_reg [4];
    logic [7:0]  duty_next [4];
    logic [2:0]  step_reg, step_next;

    logic [7:0]  div_rem_reg, div_rem_next;
    logic [7:0]  div_num_reg, div_num_next;
    logic [7:0]  div_quo_reg, div_quo_next;

    logic [15:0] mul_a;
    logic [8:0]  mul_b;
    logic [24:0] mul_p;

    logic [7:0]  div_den;
    logic [8:0]  div_trial;
    logic [8:0]  div_diff;
    logic        div_ge;
    logic [7:0]  div_rem_step;
    logic [7:0]  div_quo_step;

    logic [7:0]  brt_base;
    logic [7:0]  brt_cfg;
    logic [7:0]  spon_cfg;
    logic [11:0] spd_sum;
    logic [24:0] phase_sum;
    logic [1:0]  rot_idx;
    logic [5:0]  rot_f;
    logic [5:0]  rot_r;
    logic [7:0]  glow_cp;
    logic [7:0]  glow_v;
    logic [15:0] body_sum;
    logic [7:0]  body_term;
    logic [1:0]  body_pos;
    logic        animated;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign duty_0         = duty_reg[0];
    assign duty_1         = duty_reg[1];
    assign duty_2         = duty_reg[2];
    assign duty_3         = duty_reg[3];
    assign sponson_level  = spon_reg;
    assign shift_count    = count_reg;
    assign inserted_level = ins_reg;

    assign animated = (mode_reg == MODE_ROTATE) || (mode_reg == MODE_GLOW);

    always_comb
    begin
        brt_base = (bright_reg > BRT_FLOOR) ? bright_reg[10:3] : 8'd0;
        unique case (level_reg)
            LEVEL_LOW:
            begin
                brt_cfg  = brt_base >> 3;
                spon_cfg = SPON_LOW;
            end
            LEVEL_HIGH:
            begin
                brt_cfg  = brt_base;
                spon_cfg = SPON_HIGH;
            end
            default:
            begin
                brt_cfg  = 8'd0;
                spon_cfg = 8'd0;
            end
        endcase
        spd_sum = {1'b0, throttle_reg} + THR_ROUND;
    end

    assign rot_idx = cp_reg[7:6];
    assign rot_f   = cp_reg[5:0];
    assign rot_r   = ~cp_reg[5:0];
    assign glow_cp = cp_reg[7] ? ~cp_reg : cp_reg;
    assign glow_v  = {glow_cp[6:0], 1'b0};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_PHASE:
            begin
                mul_a = now_reg;
                mul_b = {1'b0, spd_reg};
            end
            ST_MOVE:
            begin
                mul_a = {10'd0, count_reg};
                mul_b = {1'b0, freq_reg};
            end
            ST_BODY:
            begin
                case (step_reg[1:0])
                    2'd0:
                    begin
                        mul_a = {10'd0, rot_r};
                        mul_b = {3'd0, rot_r};
                    end
                    2'd1:
                    begin
                        mul_a = {10'd0, rot_f};
                        mul_b = {3'd0, rot_r} + FRAC_ONE;
                    end
                    2'd2:
                    begin
                        mul_a = {10'd0, rot_r};
                        mul_b = {3'd0, rot_f} + FRAC_ONE;
                    end
                    default:
                    begin
                        mul_a = {10'd0, rot_f};
                        mul_b = {3'd0, rot_f};
                    end
                endcase
            end
            ST_SCALE:
            begin
                mul_a = {8'd0, v_reg[step_reg[1:0]]};
                mul_b = {1'b0, brt_reg} + 9'd1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {9'd0, mul_a} * {16'd0, mul_b};

    assign phase_sum = mul_p + {16'd0, FRAC_ONE};

    always_comb
    begin
        body_sum = mul_p[15:0] + ROUND_HALF;
        case (step_reg[1:0])
            2'd1:    body_term = body_sum[12:5] + {rot_r, rot_r[5:4]};
            2'd2:    body_term = body_sum[12:5] + {rot_f, rot_f[5:4]};
            default: body_term = body_sum[12:5];
        endcase
        body_pos = rot_idx + step_reg[1:0];
    end

    assign div_den      = (state_reg == ST_FREQ) ? spd_reg : freq_reg;
    assign div_trial    = {div_rem_reg, div_num_reg[7]};
    assign div_ge       = (div_trial >= {1'b0, div_den});
    assign div_diff     = div_trial - {1'b0, div_den};
    assign div_rem_step = div_ge ? div_diff[7:0] : div_trial[7:0];
    assign div_quo_step = {div_quo_reg[6:0], div_ge};

    always_comb
    begin
        state_next   = state_reg;
        lmt_next     = lmt_reg;
        now_next     = now_reg;
        brt_next     = brt_reg;
        spon_next    = spon_reg;
        spd_next     = spd_reg;
        cp_next      = cp_reg;
        freq_next    = freq_reg;
        count_next   = count_reg;
        ins_next     = ins_reg;
        v_next       = v_reg;
        duty_next    = duty_reg;
        step_next    = step_reg;
        div_rem_next = div_rem_reg;
        div_num_next = div_num_reg;
        div_quo_next = div_quo_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next  = now_ms;
                    brt_next  = brt_cfg;
                    spon_next = spon_cfg;
                    spd_next  = spd_sum[11:4];
                    if (animated)
                    begin
                        state_next = ST_PHASE;
                    end
                    else
                    begin
                        duty_next[0] = brt_cfg;
                        duty_next[1] = brt_cfg;
                        duty_next[2] = brt_cfg;
                        duty_next[3] = brt_cfg;
                        count_next   = '0;
                        ins_next     = '0;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_PHASE:
            begin
                cp_next      = phase_sum[14:7];
                div_rem_next = {6'd0, MOVE_NUM[9:8]};
                div_num_next = MOVE_NUM[7:0];
                div_quo_next = '0;
                step_next    = '0;
                state_next   = ST_FREQ;
            end
            ST_FREQ:
            begin
                div_rem_next = div_rem_step;
                div_num_next = {div_num_reg[6:0], 1'b0};
                div_quo_next = div_quo_step;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    freq_next    = (spd_reg < SPD_MIN) ? FREQ_MAX : div_quo_step;
                    div_rem_next = '0;
                    div_num_next = now_reg[7:0] - lmt_reg;
                    div_quo_next = '0;
                    state_next   = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                div_rem_next = div_rem_step;
                div_num_next = {div_num_reg[6:0], 1'b0};
                div_quo_next = div_quo_step;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    count_next = div_quo_step[5:0];
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                lmt_next   = lmt_reg + mul_p[7:0];
                step_next  = '0;
                state_next = ST_BODY;
            end
            ST_BODY:
            begin
                if (mode_reg == MODE_GLOW)
                begin
                    v_next[0]  = glow_v;
                    v_next[1]  = glow_v;
                    v_next[2]  = glow_v;
                    v_next[3]  = glow_v;
                    ins_next   = glow_v;
                    step_next  = '0;
                    state_next = ST_SCALE;
                end
                else
                begin
                    v_next[body_pos] = body_term;
                    if (body_pos == 2'd3)
                    begin
                        ins_next = body_term;
                    end
                    step_next = step_reg + 3'd1;
                    if (step_reg[1:0] == 2'd3)
                    begin
                        step_next  = '0;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                duty_next[step_reg[1:0]] = mul_p[15:8];
                step_next = step_reg + 3'd1;
                if (step_reg[1:0] == 2'd3)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SOLID;
            level_reg    <= LEVEL_OFF;
            bright_reg   <= '0;
            throttle_reg <= '0;
            lmt_reg      <= '0;
        end
        else
        begin
            lmt_reg <= lmt_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MODE:     mode_reg     <= cfg_data[1:0];
                    CFG_LEVEL:    level_reg    <= cfg_data[1:0];
                    CFG_BRIGHT:   bright_reg   <= cfg_data;
                    CFG_THROTTLE: throttle_reg <= cfg_data;
                    default:      mode_reg     <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        brt_reg     <= brt_next;
        spon_reg    <= spon_next;
        spd_reg     <= spd_next;
        cp_reg      <= cp_next;
        freq_reg    <= freq_next;
        count_reg   <= count_next;
        ins_reg     <= ins_next;
        v_reg       <= v_next;
        duty_reg    <= duty_next;
        step_reg    <= step_next;
        div_rem_reg <= div_rem_next;
        div_num_reg <= div_num_next;
        div_quo_reg <= div_quo_next;
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a tick transfer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shift_count <= SHIFT_MAX))
        else $error("shift count out of range");

    a_spon_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sponson_level == 8'd0 || sponson_level == SPON_LOW
                       || sponson_level == SPON_HIGH))
        else $error("sponson level is not a defined intensity");

    a_freq_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT) |-> (freq_reg != 8'd0))
        else $error("zero move interval used as divisor");

endmodule

// ===== tb/sv/lla_tick_checker.sv =====
// Checker for the LED light animator: watches the config, tick and result channels.
// Predicts one result per accepted tick and compares each result transfer field by field.
// Depends on lla_pkg.
module lla_tick_checker
    import lla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] now_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  duty_0,
    input  logic [7:0]  duty_1,
    input  logic [7:0]  duty_2,
    input  logic [7:0]  duty_3,
    input  logic [7:0]  sponson_level,
    input  logic [5:0]  shift_count,
    input  logic [7:0]  inserted_level,
    output int          ticks_in_flight,
    output int          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0][7:0] duty;
        logic [7:0]      sponson;
        logic [5:0]      shifts;
        logic [7:0]      inserted;
    } light_frame_t;

    logic [1:0]   mode_q;
    logic [1:0]   level_q;
    logic [10:0]  bright_q;
    logic [10:0]  throttle_q;
    logic [7:0]   wing_mark;
    light_frame_t frames_due[$];

    function automatic light_frame_t animate_tick(input logic [15:0] now);
        light_frame_t fr;
        int unsigned  brt, spon, spd, interval, phase, f, r, idx, diff, shifts;
        int unsigned  body [4];
        brt = 0;
        spon = 0;
        shifts = 0;
        body = '{default: 0};
        if (bright_q > BRT_FLOOR) begin
            brt = 32'(bright_q) >> 3;
            if (brt > 255)
                brt = 255;
        end
        case (level_q)
            LEVEL_LOW:
            begin
                spon = 32'(SPON_LOW);
                brt = brt >> 3;
            end
            LEVEL_HIGH: spon = 32'(SPON_HIGH);
            default:
            begin
                brt = 0;
                spon = 0;
            end
        endcase
        spd = (32'(throttle_q) + THR_ROUND) >> 4;
        interval = (spd == 0) ? 32'(FREQ_MAX) : 32'(MOVE_NUM) / spd;
        if (interval > 255)
            interval = 255;
        fr.sponson = spon[7:0];
        if (mode_q == MODE_ROTATE || mode_q == MODE_GLOW) begin
            phase = ((32'(now) * spd + FRAC_ONE) >> 7) & 32'hFF;
            if (mode_q == MODE_ROTATE) begin
                idx = (phase >> 6) & 3;
                f = phase & (FRAC_ONE - 1);
                r = (FRAC_ONE - 1) - f;
                body[idx] = ((r * r + ROUND_HALF) >> 5) & 32'hFF;
                idx = (idx + 1) & 3;
                body[idx] = ((((r + FRAC_ONE) * f + ROUND_HALF) >> 5)
                            + ((r << 2) | (r >> 4))) & 32'hFF;
                idx = (idx + 1) & 3;
                body[idx] = (((f << 2) | (f >> 4))
                            + (((f + FRAC_ONE) * r + ROUND_HALF) >> 5)) & 32'hFF;
                idx = (idx + 1) & 3;
                body[idx] = ((f * f + ROUND_HALF) >> 5) & 32'hFF;
            end
            else begin
                if (phase & 32'h80)
                    phase = 255 - phase;
                for (int k = 0; k < 4; k++)
                    body[k] = (phase << 1) & 32'hFF;
            end
            diff = (32'(now) - 32'(wing_mark)) & 32'hFF;
            shifts = diff / interval;
            wing_mark = 8'(32'(wing_mark) + shifts * interval);
            fr.inserted = body[3][7:0];
            for (int k = 0; k < 4; k++)
                fr.duty[k] = 8'((body[k] * (brt + 1)) >> 8);
        end
        else begin
            for (int k = 0; k < 4; k++)
                fr.duty[k] = brt[7:0];
            fr.inserted = 8'd0;
        end
        fr.shifts = shifts[5:0];
        return fr;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        light_frame_t want;
        if (!rst_n) begin
            mode_q = MODE_SOLID;
            level_q = LEVEL_OFF;
            bright_q = '0;
            throttle_q = '0;
            wing_mark = '0;
            frames_due.delete();
            mismatch_count = 0;
            ticks_in_flight <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MODE:     mode_q = cfg_data[1:0];
                    CFG_LEVEL:    level_q = cfg_data[1:0];
                    CFG_BRIGHT:   bright_q = cfg_data;
                    CFG_THROTTLE: throttle_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                frames_due.push_back(animate_tick(now_ms));
            if (out_valid && out_ready) begin
                if (frames_due.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t: result transfer with no tick pending, duties %0d %0d %0d %0d",
                             $time, duty_0, duty_1, duty_2, duty_3);
                end
                else begin
                    want = frames_due.pop_front();
                    check_field("duty_0", want.duty[0], duty_0);
                    check_field("duty_1", want.duty[1], duty_1);
                    check_field("duty_2", want.duty[2], duty_2);
                    check_field("duty_3", want.duty[3], duty_3);
                    check_field("sponson_level", want.sponson, sponson_level);
                    check_field("shift_count", {2'b00, want.shifts}, {2'b00, shift_count});
                    check_field("inserted_level", want.inserted, inserted_level);
                end
            end
            ticks_in_flight <= frames_due.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the LED light animator testbench: clock, reset, tick and config stimulus.
// Instantiates led_light_animator and lla_tick_checker, which predicts and compares.
// Depends on lla_pkg.
module testbench;
    import lla_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] LEVEL_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MODE;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  duty_0, duty_1, duty_2, duty_3;
    logic [7:0]  sponson_level;
    logic [5:0]  shift_count;
    logic [7:0]  inserted_level;
    int          ticks_in_flight;
    int          mismatch_count;
    bit          no_idle = 1'b0;
    bit          hold_off_req = 1'b0;

    led_light_animator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .duty_0(duty_0), .duty_1(duty_1), .duty_2(duty_2), .duty_3(duty_3),
        .sponson_level(sponson_level), .shift_count(shift_count),
        .inserted_level(inserted_level)
    );

    lla_tick_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .duty_0(duty_0), .duty_1(duty_1), .duty_2(duty_2), .duty_3(duty_3),
        .sponson_level(sponson_level), .shift_count(shift_count),
        .inserted_level(inserted_level),
        .ticks_in_flight(ticks_in_flight), .mismatch_count(mismatch_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("led_light_animator: mismatch");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    task automatic send_tick(input logic [15:0] t);
        int gap;
        gap = (!no_idle && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms <= t;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ticks_in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [10:0] mode_w, input logic [10:0] level_w,
                             input logic [10:0] bright_w, input logic [10:0] thr_w);
        settle();
        cfg_write(CFG_MODE, mode_w);
        cfg_write(CFG_LEVEL, level_w);
        cfg_write(CFG_BRIGHT, bright_w);
        cfg_write(CFG_THROTTLE, thr_w);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                out_ready <= 1'b0;
            end
            else if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (stall > 0) begin
                out_ready <= 1'b0;
                stall = stall - 1;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                stall = idle_len() - 1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [15:0] t;
        logic [10:0] mode_w, level_w, bright_w, thr_w;
        int          sent, phase, n, r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(16'h0000);
        configure(11'(MODE_SOLID), 11'(LEVEL_HIGH), 11'h7FF, 11'd0);
        send_tick(16'hFFFF);
        configure(11'(MODE_ROTATE), 11'(LEVEL_HIGH), 11'h7FF, 11'h7FF);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd63);
        send_tick(16'd64);
        send_tick(16'd127);
        send_tick(16'd255);
        send_tick(16'd256);
        send_tick(16'hFFFF);
        configure(11'(MODE_GLOW), 11'(LEVEL_LOW), BRT_FLOOR, 11'd0);
        send_tick(16'd0);
        send_tick(16'd254);
        send_tick(16'd255);
        send_tick(16'd509);
        send_tick(16'hFFFF);
        configure({9'h1FF, MODE_SPARE}, {9'h1FF, LEVEL_SPARE}, 11'd1000, 11'd500);
        send_tick(16'd100);
        send_tick(16'd200);
        configure(11'(MODE_ROTATE), 11'(LEVEL_LOW), BRT_FLOOR + 11'd1, 11'd8);
        send_tick(16'd0);
        send_tick(16'd700);
        send_tick(16'd1400);
        configure(11'(MODE_GLOW), 11'(LEVEL_HIGH), 11'd300, 11'd1024);
        send_tick(16'd1000);
        send_tick(16'd1001);
        send_tick(16'd30000);
        configure(11'(MODE_ROTATE), 11'(LEVEL_OFF), 11'h7FF, 11'd1500);
        send_tick(16'd500);
        send_tick(16'd501);

        sent = 0;
        phase = 0;
        while (sent < 800) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mode_w = 11'(MODE_ROTATE);
                4, 5, 6, 7: mode_w = 11'(MODE_GLOW);
                8:          mode_w = 11'(MODE_SOLID);
                default:    mode_w = 11'(MODE_SPARE);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2:    level_w = 11'(LEVEL_LOW);
                3, 4, 5, 6: level_w = 11'(LEVEL_HIGH);
                7, 8:       level_w = 11'(LEVEL_OFF);
                default:    level_w = 11'(LEVEL_SPARE);
            endcase
            if ($urandom_range(0, 1) == 1)
                mode_w[10:2] = 9'($urandom);
            if ($urandom_range(0, 1) == 1)
                level_w[10:2] = 9'($urandom);
            case ($urandom_range(0, 9))
                0:       bright_w = 11'd0;
                1:       bright_w = BRT_FLOOR;
                2:       bright_w = BRT_FLOOR + 11'd1;
                3:       bright_w = 11'h7FF;
                default: bright_w = 11'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       thr_w = 11'd0;
                1:       thr_w = 11'd7;
                2:       thr_w = 11'd8;
                3:       thr_w = 11'h7FF;
                4:       thr_w = 11'($urandom_range(0, 40));
                default: thr_w = 11'($urandom);
            endcase
            no_idle = (phase % 5 == 4);
            configure(mode_w, level_w, bright_w, thr_w);
            if (phase == 3)
                hold_off_req = 1'b1;
            n = $urandom_range(20, 60);
            t = 16'($urandom);
            repeat (n) begin
                send_tick(t);
                sent = sent + 1;
                r = $urandom_range(0, 99);
                if (r < 70)
                    t = t + 16'd1;
                else if (r < 85)
                    t = t + 16'($urandom_range(2, 40));
                else if (r < 95)
                    t = t + 16'($urandom_range(41, 700));
                else
                    t = 16'($urandom);
            end
            phase = phase + 1;
        end
        no_idle = 1'b0;

        settle();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("led_light_animator: match");
        else
            $display("led_light_animator: mismatch");
        $finish;
    end

endmodule
